// ----- src/kfr_pkg.sv -----
// shared types, constants and microcode encodings for the rate fusion filter
package kfr_pkg;

  localparam int unsigned RateW  = 16;
  localparam int unsigned VarW   = 24;
  localparam int unsigned DenW   = VarW + 1;
  localparam int unsigned DivW   = 2 * VarW;
  localparam int unsigned AccW   = VarW + RateW + 2;
  localparam int unsigned PcW    = 4;

  localparam logic [VarW-1:0]  VarMax          = {VarW{1'b1}};
  localparam logic [VarW-1:0]  ProcessVarReset = 24'd1024;
  localparam logic [VarW-1:0]  SensorVarReset  = 24'd128;
  localparam logic [VarW-1:0]  StartVarReset   = 24'd256000;

  // register indexes on the configuration port (word address)
  localparam logic [1:0] RegProcessVar = 2'd0;
  localparam logic [1:0] RegSensorVar  = 2'd1;
  localparam logic [1:0] RegStartVar   = 2'd2;

  // input kinds carried in tuser
  localparam logic ActGyro     = 1'b0;
  localparam logic ActOdometry = 1'b1;

  // microprogram step addresses
  localparam logic [PcW-1:0] StIdle     = 4'd0;
  localparam logic [PcW-1:0] StGyro     = 4'd1;
  localparam logic [PcW-1:0] StSeed     = 4'd2;
  localparam logic [PcW-1:0] StPredict  = 4'd3;
  localparam logic [PcW-1:0] StDenom    = 4'd4;
  localparam logic [PcW-1:0] StMulGyro  = 4'd5;
  localparam logic [PcW-1:0] StSum      = 4'd6;
  localparam logic [PcW-1:0] StDivMean  = 4'd7;
  localparam logic [PcW-1:0] StWaitMean = 4'd8;
  localparam logic [PcW-1:0] StSetMean  = 4'd9;
  localparam logic [PcW-1:0] StDivVar   = 4'd10;
  localparam logic [PcW-1:0] StWaitVar  = 4'd11;
  localparam logic [PcW-1:0] StSetVar   = 4'd12;
  localparam logic [PcW-1:0] StZeroVar  = 4'd13;
  localparam logic [PcW-1:0] StEmit     = 4'd14;
  localparam logic [PcW-1:0] StReturn   = 4'd15;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_GYRO,
    OP_SEED,
    OP_PREDICT,
    OP_DENOM,
    OP_MUL_GYRO,
    OP_SUM,
    OP_DIV_MEAN,
    OP_SET_MEAN,
    OP_DIV_VAR,
    OP_SET_VAR,
    OP_ZERO_VAR,
    OP_EMIT
  } kfr_op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_GYRO,
    C_FIRST,
    C_DEN_ZERO,
    C_DIV_BUSY,
    C_OUT_BUSY
  } kfr_cond_e;

  typedef struct packed {
    kfr_op_e        op;
    kfr_cond_e      cond;
    logic [PcW-1:0] target;
  } kfr_ctl_t;

  typedef struct packed {
    logic is_gyro;
    logic first;
    logic den_zero;
    logic div_busy;
  } kfr_stat_t;

  typedef struct packed {
    logic [VarW-1:0] process_var;
    logic [VarW-1:0] sensor_var;
    logic [VarW-1:0] start_var;
  } kfr_cfg_t;

endpackage

// ----- src/kfr_div.sv -----
// iterative unsigned divider, two quotient bits per cycle
module kfr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kfr_pkg::DivW-1:0]  dividend_i,
  input  logic [kfr_pkg::DenW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [kfr_pkg::DivW-1:0]  quotient_o
);
  import kfr_pkg::*;

  localparam int unsigned Steps = DivW / 2;
  localparam int unsigned CntW  = $clog2(Steps);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   div_q, div_d;
  logic [DivW-1:0]   quo_q, quo_d;
  logic [DenW-1:0]   rem_step;
  logic [DivW-1:0]   quo_step;
  logic [DenW:0]     trial;

  // two restoring steps per cycle
  always_comb begin
    rem_step = rem_q;
    quo_step = quo_q;
    trial    = '0;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_step, quo_step[DivW-1]};
      quo_step = {quo_step[DivW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_step    = DenW'(trial - {1'b0, div_q});
        quo_step[0] = 1'b1;
      end else begin
        rem_step = trial[DenW-1:0];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Steps - 1);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = rem_step;
      quo_d = quo_step;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/kfr_seq.sv -----
// microprogram sequencer: step counter, control store and jump logic
module kfr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kfr_pkg::kfr_stat_t  stat_i,
  input  logic                in_valid_i,
  input  logic                out_busy_i,
  output kfr_pkg::kfr_ctl_t   ctl_o,
  output logic                idle_o
);
  import kfr_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  kfr_ctl_t       ctl;
  logic           take;

  function automatic kfr_ctl_t ucode(input logic [PcW-1:0] pc);
    kfr_ctl_t w;
    w = '{op: OP_NONE, cond: C_NEVER, target: StIdle};
    unique case (pc)
      StIdle:     w = '{op: OP_CAPTURE,  cond: C_NO_INPUT, target: StIdle};
      StGyro:     w = '{op: OP_GYRO,     cond: C_GYRO,     target: StIdle};
      StSeed:     w = '{op: OP_SEED,     cond: C_FIRST,    target: StIdle};
      StPredict:  w = '{op: OP_PREDICT,  cond: C_NEVER,    target: StIdle};
      StDenom:    w = '{op: OP_DENOM,    cond: C_NEVER,    target: StIdle};
      StMulGyro:  w = '{op: OP_MUL_GYRO, cond: C_DEN_ZERO, target: StZeroVar};
      StSum:      w = '{op: OP_SUM,      cond: C_NEVER,    target: StIdle};
      StDivMean:  w = '{op: OP_DIV_MEAN, cond: C_NEVER,    target: StIdle};
      StWaitMean: w = '{op: OP_NONE,     cond: C_DIV_BUSY, target: StWaitMean};
      StSetMean:  w = '{op: OP_SET_MEAN, cond: C_NEVER,    target: StIdle};
      StDivVar:   w = '{op: OP_DIV_VAR,  cond: C_NEVER,    target: StIdle};
      StWaitVar:  w = '{op: OP_NONE,     cond: C_DIV_BUSY, target: StWaitVar};
      StSetVar:   w = '{op: OP_SET_VAR,  cond: C_ALWAYS,   target: StEmit};
      StZeroVar:  w = '{op: OP_ZERO_VAR, cond: C_NEVER,    target: StIdle};
      StEmit:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: StEmit};
      StReturn:   w = '{op: OP_NONE,     cond: C_ALWAYS,   target: StIdle};
      default:    w = '{op: OP_NONE,     cond: C_ALWAYS,   target: StIdle};
    endcase
    return w;
  endfunction

  assign ctl = ucode(pc_q);

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !in_valid_i;
      C_GYRO:     take = stat_i.is_gyro;
      C_FIRST:    take = stat_i.first;
      C_DEN_ZERO: take = stat_i.den_zero;
      C_DIV_BUSY: take = stat_i.div_busy;
      C_OUT_BUSY: take = out_busy_i;
      default:    take = 1'b0;
    endcase
  end

  assign pc_d = take ? ctl.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o  = ctl;
  assign idle_o = (pc_q == StIdle);

endmodule

// ----- src/kfr_dp.sv -----
// filter datapath: state registers, multipliers, saturation and shared divider
module kfr_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kfr_pkg::kfr_ctl_t          ctl_i,
  input  kfr_pkg::kfr_cfg_t          cfg_i,
  input  logic                       in_fire_i,
  input  logic                       in_action_i,
  input  logic [kfr_pkg::RateW-1:0]  in_sample_i,
  output kfr_pkg::kfr_stat_t         stat_o,
  output logic [kfr_pkg::RateW-1:0]  mean_o,
  output logic [kfr_pkg::VarW-1:0]   var_o
);
  import kfr_pkg::*;

  localparam logic signed [RateW+1:0] RateMax18 = 18'sd32767;
  localparam logic signed [RateW+1:0] RateMin18 = -18'sd32768;
  localparam logic [DivW-1:0] QuoPosMax = DivW'(32767);
  localparam logic [DivW-1:0] QuoNegMax = DivW'(32768);

  logic                     action_q;
  logic signed [RateW-1:0]  sample_q;
  logic signed [RateW-1:0]  mean_q, mean_d;
  logic        [VarW-1:0]   var_q, var_d;
  logic signed [RateW-1:0]  gyro_q, gyro_d;
  logic signed [RateW-1:0]  prev_q, prev_d;
  logic                     first_q, first_d;
  logic        [DenW-1:0]   den_q, den_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic        [DivW-1:0]   prod_q, prod_d;
  logic                     neg_q, neg_d;

  logic signed [RateW+1:0]  pred_sum;
  logic        [DenW-1:0]   var_sum;
  logic signed [AccW-1:0]   mul_rm;
  logic signed [DivW-1:0]   mul_pg;
  logic        [DivW-1:0]   mul_pr;
  logic        [AccW-1:0]   acc_mag;
  logic                     div_start;
  logic        [DivW-1:0]   div_dividend;
  logic                     div_busy;
  logic        [DivW-1:0]   quotient;
  logic signed [RateW-1:0]  mean_quo;
  logic        [VarW-1:0]   var_quo;

  assign pred_sum = (RateW+2)'(mean_q) + (RateW+2)'(sample_q) - (RateW+2)'(prev_q);
  assign var_sum  = {1'b0, var_q} + {1'b0, cfg_i.process_var};
  assign mul_rm   = $signed({1'b0, cfg_i.sensor_var}) * mean_q;
  assign mul_pg   = $signed({1'b0, var_q}) * gyro_q;
  assign mul_pr   = var_q * cfg_i.sensor_var;
  assign acc_mag  = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);

  // quotient back to a saturated signed rate and a saturated variance
  always_comb begin
    if (!neg_q) begin
      mean_quo = (quotient > QuoPosMax) ? RateMax18[RateW-1:0] : quotient[RateW-1:0];
    end else if (quotient > QuoNegMax) begin
      mean_quo = RateMin18[RateW-1:0];
    end else begin
      mean_quo = RateW'(-quotient[RateW-1:0]);
    end
    var_quo = (quotient > DivW'(VarMax)) ? VarMax : quotient[VarW-1:0];
  end

  assign div_start    = (ctl_i.op == OP_DIV_MEAN) || (ctl_i.op == OP_DIV_VAR);
  assign div_dividend = (ctl_i.op == OP_DIV_MEAN) ? DivW'(acc_mag) : prod_q;

  always_comb begin
    mean_d  = mean_q;
    var_d   = var_q;
    gyro_d  = gyro_q;
    prev_d  = prev_q;
    first_d = first_q;
    den_d   = den_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    case (ctl_i.op)
      OP_GYRO: begin
        if (action_q == ActGyro) begin
          gyro_d = sample_q;
        end
      end
      OP_SEED: begin
        if (first_q) begin
          mean_d  = sample_q;
          var_d   = cfg_i.start_var;
          prev_d  = sample_q;
          first_d = 1'b0;
        end
      end
      OP_PREDICT: begin
        if (pred_sum > RateMax18) begin
          mean_d = RateMax18[RateW-1:0];
        end else if (pred_sum < RateMin18) begin
          mean_d = RateMin18[RateW-1:0];
        end else begin
          mean_d = pred_sum[RateW-1:0];
        end
        prev_d = sample_q;
        var_d  = var_sum[VarW] ? VarMax : var_sum[VarW-1:0];
      end
      OP_DENOM: begin
        den_d = {1'b0, var_q} + {1'b0, cfg_i.sensor_var};
        acc_d = mul_rm;
      end
      OP_MUL_GYRO: prod_d = mul_pg;
      OP_SUM:      acc_d  = acc_q + $signed(prod_q[AccW-1:0]);
      OP_DIV_MEAN: neg_d  = acc_q[AccW-1];
      OP_SET_MEAN: begin
        mean_d = mean_quo;
        prod_d = mul_pr;
      end
      OP_SET_VAR:  var_d = var_quo;
      OP_ZERO_VAR: var_d = '0;
      default: ;
    endcase
  end

  // sample capture happens only on an accepted transfer
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      action_q <= in_action_i;
      sample_q <= in_sample_i;
    end
    den_q  <= den_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= '0;
      var_q   <= StartVarReset;
      gyro_q  <= '0;
      prev_q  <= '0;
      first_q <= 1'b1;
    end else begin
      mean_q  <= mean_d;
      var_q   <= var_d;
      gyro_q  <= gyro_d;
      prev_q  <= prev_d;
      first_q <= first_d;
    end
  end

  kfr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (den_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign stat_o = '{is_gyro:  (action_q == ActGyro),
                    first:    first_q,
                    den_zero: (den_q == '0),
                    div_busy: div_busy};
  assign mean_o = mean_q;
  assign var_o  = var_q;

endmodule

// ----- src/scalar_kalman_rate_fusion_core.sv -----
// top level of the scalar kalman yaw rate fusion filter
//
// input stream: one transfer per sample; tuser[0] selects the sensor (0 gyro,
// 1 odometry), tdata[15:0] is the signed q8.8 yaw rate. a gyro transfer only
// latches the newest gyro rate. the first odometry transfer after reset seeds
// the mean and loads start_variance; neither gives a result.
// every later odometry transfer runs prediction and update and gives one
// result on the output stream: tdata[15:0] fused rate (signed q8.8),
// tdata[39:16] variance (unsigned q16.8).
// a microprogram of 16 steps drives the datapath; the shared divider yields
// two quotient bits per cycle; the program waits on it in each of the two
// divisions. an update puts its result in the output register at the emit
// step and then returns to idle for the next transfer; gyro and seeding
// items return to idle from their own steps; one item is worked on at a time.
// the result sits in an output register, so the next item is accepted while it
// waits; only a second result stalls the program until the first is taken.
// reset clears the program counter and the output valid, loads the register
// defaults, zeroes the gyro latch and arms the seeding of the first odometry.
// configuration goes over the apb port at byte addresses 0, 4 and 8.
module scalar_kalman_rate_fusion_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] rate_sample
  input  logic        s_axis_tuser,   // [0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] filtered_rate, [39:16] estimate_variance
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kfr_pkg::*;

  kfr_cfg_t          cfg_q;
  kfr_ctl_t          ctl;
  kfr_stat_t         stat;
  logic              idle;
  logic              in_fire;
  logic              out_busy;
  logic              emit;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic [RateW-1:0]  mean;
  logic [VarW-1:0]   var_est;
  logic              out_valid_q, out_valid_d;
  logic [39:0]       out_data_q;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_var <= ProcessVarReset;
      cfg_q.sensor_var  <= SensorVarReset;
      cfg_q.start_var   <= StartVarReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegProcessVar: cfg_q.process_var <= pwdata[VarW-1:0];
        RegSensorVar:  cfg_q.sensor_var  <= pwdata[VarW-1:0];
        RegStartVar:   cfg_q.start_var   <= pwdata[VarW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegProcessVar: prdata = {8'd0, cfg_q.process_var};
      RegSensorVar:  prdata = {8'd0, cfg_q.sensor_var};
      RegStartVar:   prdata = {8'd0, cfg_q.start_var};
      default:       prdata = '0;
    endcase
  end

  // input handshake: samples are taken only while the program sits idle
  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // the emit step holds while the previous result is still unclaimed
  assign out_busy = out_valid_q && !m_axis_tready;
  assign emit     = (ctl.op == OP_EMIT) && !out_busy;

  kfr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_busy),
    .ctl_o      (ctl),
    .idle_o     (idle)
  );

  kfr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_i       (cfg_q),
    .in_fire_i   (in_fire),
    .in_action_i (s_axis_tuser),
    .in_sample_i (s_axis_tdata),
    .stat_o      (stat),
    .mean_o      (mean),
    .var_o       (var_est)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {var_est, mean};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
